// ===== hdl/cpm_pkg.sv =====
// cpm_pkg: shared types, constants and compare functions for the chunk pattern matcher
// used by cpm_front, cpm_queue, cpm_back, the top level and the checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cpm_pkg;

	localparam int MAX_PATTERN   = 8;
	localparam int POSITION_BITS = 17;
	localparam int WIN_BYTES     = 8;
	localparam int WIN_BITS      = WIN_BYTES * 8;
	localparam int LEN_BITS      = 4;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 64;

	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_BYTES  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 2'd1;

	// result class codes
	localparam logic [2:0] CLS_NONE         = 3'd0;
	localparam logic [2:0] CLS_WHOLE        = 3'd1;
	localparam logic [2:0] CLS_PREFIX_END   = 3'd2;
	localparam logic [2:0] CLS_SUFFIX_START = 3'd3;
	localparam logic [2:0] CLS_BOTH         = 3'd4;

	// summary of one finished chunk, handed from front to back
	typedef struct packed {
		logic                whole;
		logic [WIN_BITS-1:0] head_win;
		logic [WIN_BITS-1:0] recent_win;
		logic [LEN_BITS-1:0] cnt;
		logic [LEN_BITS-1:0] len;
	} chunk_sum_t;

	// clamp the length register to 1..MAX_PATTERN
	function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] raw);
		logic [LEN_BITS-1:0] r;
		r = raw;
		if (raw == '0)
			r = LEN_BITS'(1);
		else if (raw > LEN_BITS'(MAX_PATTERN))
			r = LEN_BITS'(MAX_PATTERN);
		return r;
	endfunction

	function automatic logic [7:0] byte_at(input logic [WIN_BITS-1:0] w,
	                                        input logic [2:0] k);
		return w[k*8 +: 8];
	endfunction

	// shortest i where chunk start equals pattern suffix of length i
	function automatic logic [LEN_BITS-1:0] head_match(input logic [WIN_BITS-1:0] hw,
	                                                   input logic [WIN_BITS-1:0] pat,
	                                                   input logic [LEN_BITS-1:0] len,
	                                                   input logic [LEN_BITS-1:0] bound);
		logic [LEN_BITS-1:0] r;
		logic                eq;
		logic [2:0]          k;
		r = '0;
		for (int i = MAX_PATTERN; i >= 1; i--) begin
			eq = 1'b1;
			for (int j = 0; j < MAX_PATTERN; j++) begin
				k = 3'(int'(len) - i + j);
				if (j < i && byte_at(hw, 3'(j)) != byte_at(pat, k))
					eq = 1'b0;
			end
			if (eq && LEN_BITS'(i) <= bound)
				r = LEN_BITS'(i);
		end
		return r;
	endfunction

	// shortest i where chunk end equals pattern prefix of length i
	function automatic logic [LEN_BITS-1:0] tail_match(input logic [WIN_BITS-1:0] rw,
	                                                   input logic [WIN_BITS-1:0] pat,
	                                                   input logic [LEN_BITS-1:0] bound);
		logic [LEN_BITS-1:0] r;
		logic                eq;
		r = '0;
		for (int i = MAX_PATTERN; i >= 1; i--) begin
			eq = 1'b1;
			for (int j = 0; j < MAX_PATTERN; j++) begin
				if (j < i && byte_at(rw, 3'(i - 1 - j)) != byte_at(pat, 3'(j)))
					eq = 1'b0;
			end
			if (eq && LEN_BITS'(i) <= bound)
				r = LEN_BITS'(i);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/cpm_front.sv =====
// cpm_front: takes chunk bytes, keeps the windows and the whole-pattern flag
// depends on cpm_pkg; pushes one chunk summary per chunk into cpm_queue
`timescale 1ns / 1ps
`default_nettype none

module cpm_front import cpm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [WIN_BITS-1:0] pat,
	input  wire logic [LEN_BITS-1:0] len,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [7:0]          chunk_byte,
	input  wire logic                chunk_end,
	output logic                     push,
	output chunk_sum_t               push_data,
	input  wire logic                q_full
);

	logic [WIN_BITS-1:0]      recent_q, head_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     whole_q;

	logic [WIN_BITS-1:0]      recent_nx, head_nx;
	logic [POSITION_BITS-1:0] pos_nx;
	logic [MAX_PATTERN-1:0]   eq_len;
	logic                     hit, take;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign push     = take && chunk_end;

	always_comb begin
		recent_nx = {recent_q[WIN_BITS-9:0], chunk_byte};
		head_nx   = head_q;
		for (int k = 0; k < WIN_BYTES; k++) begin
			if (pos_q == POSITION_BITS'(k))
				head_nx[k*8 +: 8] = chunk_byte;
		end
		pos_nx = (pos_q == POS_MAX) ? pos_q : pos_q + POSITION_BITS'(1);
		// one compare set per candidate length, picked by the live length
		for (int l = 1; l <= MAX_PATTERN; l++) begin
			eq_len[l-1] = 1'b1;
			for (int j = 0; j < MAX_PATTERN; j++) begin
				if (j < l && pat[j*8 +: 8] != recent_nx[(l-1-j)*8 +: 8])
					eq_len[l-1] = 1'b0;
			end
		end
		hit = eq_len[3'(len - LEN_BITS'(1))] && (pos_nx >= POSITION_BITS'(len));
	end

	always_comb begin
		push_data.whole      = whole_q || hit;
		push_data.head_win   = head_nx;
		push_data.recent_win = recent_nx;
		push_data.cnt        = (pos_nx >= POSITION_BITS'(WIN_BYTES)) ?
		                       LEN_BITS'(WIN_BYTES) : pos_nx[LEN_BITS-1:0];
		push_data.len        = len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			head_q   <= '0;
			pos_q    <= '0;
			whole_q  <= 1'b0;
		end else if (take) begin
			if (chunk_end) begin
				recent_q <= '0;
				head_q   <= '0;
				pos_q    <= '0;
				whole_q  <= 1'b0;
			end else begin
				recent_q <= recent_nx;
				head_q   <= head_nx;
				pos_q    <= pos_nx;
				whole_q  <= whole_q || hit;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/cpm_queue.sv =====
// cpm_queue: two-entry queue of chunk summaries between front and back
// depends on cpm_pkg
`timescale 1ns / 1ps
`default_nettype none

module cpm_queue import cpm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire chunk_sum_t push_data,
	output logic            full,
	output logic            pop_valid,
	input  wire logic       pop,
	output chunk_sum_t      pop_data
);

	chunk_sum_t mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/cpm_back.sv =====
// cpm_back: computes the overlaps and class of one chunk, holds the result register
// depends on cpm_pkg; reads summaries from cpm_queue
`timescale 1ns / 1ps
`default_nettype none

module cpm_back import cpm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [WIN_BITS-1:0] pat,
	input  wire logic                q_valid,
	output logic                     pop,
	input  wire chunk_sum_t          q_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [2:0]               match_class,
	output logic [3:0]               head_overlap,
	output logic [3:0]               tail_overlap
);

	logic [LEN_BITS-1:0] bound, head_c, tail_c;
	logic [2:0]          cls_c;

	assign pop = q_valid && (!out_valid || out_ready);

	always_comb begin
		bound  = (q_data.cnt < q_data.len) ? q_data.cnt : q_data.len;
		head_c = '0;
		tail_c = '0;
		cls_c  = CLS_WHOLE;
		if (!q_data.whole) begin
			head_c = head_match(q_data.head_win, pat, q_data.len, bound);
			tail_c = tail_match(q_data.recent_win, pat, bound);
			priority if (head_c != '0 && tail_c != '0)
				cls_c = CLS_BOTH;
			else if (tail_c != '0)
				cls_c = CLS_PREFIX_END;
			else if (head_c != '0)
				cls_c = CLS_SUFFIX_START;
			else
				cls_c = CLS_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (pop) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			match_class  <= cls_c;
			head_overlap <= head_c;
			tail_overlap <= tail_c;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/chunk_pattern_match_with_overlap.sv =====
// chunk_pattern_match_with_overlap: top level of the chunk pattern matcher
// depends on cpm_pkg, cpm_front, cpm_queue, cpm_back
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  cfg      | cfg_we              | cfg_index, cfg_data
//  in       | in_valid / in_ready | chunk_byte, chunk_end
//  out      | out_valid/out_ready | match_class, head_overlap, tail_overlap
//
// one byte request per cycle while the queue is not full; the front window
// update and the eight parallel whole-pattern compares are combinational per byte
// after its last byte a result passes the queue write, then the
// overlap compares in the back into the result register
// reset clears the chunk state and the queue; no clearing pass
// the input stalls only when two chunk summaries wait behind a held result
`timescale 1ns / 1ps
`default_nettype none

module chunk_pattern_match_with_overlap import cpm_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [7:0]               chunk_byte,
	input  wire logic                     chunk_end,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [2:0]                    match_class,
	output logic [3:0]                    head_overlap,
	output logic [3:0]                    tail_overlap
);

	// configuration registers, written by the user only while idle; the block itself does not enforce it
	logic [WIN_BITS-1:0] pat_q;
	logic [LEN_BITS-1:0] len_raw_q;
	logic [LEN_BITS-1:0] len;

	// front to queue, queue to back
	logic       push, q_full, q_valid, pop;
	chunk_sum_t push_data, q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q     <= '0;
			len_raw_q <= LEN_BITS'(1);
		end else if (cfg_we) begin
			// indexes beyond the list are ignored
			if (cfg_index == REG_PATTERN_BYTES)
				pat_q <= cfg_data[WIN_BITS-1:0];
			else if (cfg_index == REG_PATTERN_LENGTH)
				len_raw_q <= cfg_data[LEN_BITS-1:0];
		end
	end

	// zero acts as one, anything above the maximum as the maximum
	assign len = eff_len(len_raw_q);

	// front: window tracking and whole-pattern detection per byte
	cpm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pat        (pat_q),
		.len        (len),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.chunk_byte (chunk_byte),
		.chunk_end  (chunk_end),
		.push       (push),
		.push_data  (push_data),
		.q_full     (q_full)
	);

	// short queue of finished chunks so each side stalls on its own
	cpm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (pop),
		.pop_data  (q_data)
	);

	// back: boundary overlaps, class code and result register
	cpm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pat          (pat_q),
		.q_valid      (q_valid),
		.pop          (pop),
		.q_data       (q_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.match_class  (match_class),
		.head_overlap (head_overlap),
		.tail_overlap (tail_overlap)
	);

endmodule

`default_nettype wire

// ===== hdl/cpm_checker.sv =====
// cpm_checker: port-level assertions for the chunk pattern matcher, bound to the top level
// depends on cpm_pkg and chunk_pattern_match_with_overlap
`timescale 1ns / 1ps
`default_nettype none

module cpm_checker import cpm_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] match_class,
	input wire logic [3:0] head_overlap,
	input wire logic [3:0] tail_overlap
);

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match_class)
		&& $stable(head_overlap) && $stable(tail_overlap))
		else $error("result changed while stalled");

	// whole match or no overlap carries zero lengths
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (match_class == CLS_WHOLE || match_class == CLS_NONE)
		|-> head_overlap == 4'd0 && tail_overlap == 4'd0)
		else $error("overlap lengths set with whole or no match");

	// class agrees with which overlaps are present
	a_cls_agree: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (match_class == CLS_BOTH || match_class == CLS_PREFIX_END
		|| match_class == CLS_SUFFIX_START)
		|-> (tail_overlap != 4'd0) == (match_class != CLS_SUFFIX_START)
		&& (head_overlap != 4'd0) == (match_class != CLS_PREFIX_END))
		else $error("class does not agree with overlaps");

	// lengths never exceed the longest pattern and the class code stays in range
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> head_overlap <= 4'(MAX_PATTERN) && tail_overlap <= 4'(MAX_PATTERN)
		&& match_class <= CLS_BOTH)
		else $error("result field out of range");

endmodule

bind chunk_pattern_match_with_overlap cpm_checker u_cpm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.match_class  (match_class),
	.head_overlap (head_overlap),
	.tail_overlap (tail_overlap)
);

`default_nettype wire
